>>> rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Word types, request and status codes, and sizing constants shared by the
// frame allocator modules.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int MAX_FRAMES_DEFAULT = 32768;
    localparam int FRAME_W = 20;
    localparam int COUNT_W = 16;
    localparam int EFF_W = 21;
    localparam int BIT_W = 5;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 16'd32768;
    localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_RESERVE = 2'd1;
    localparam logic [1:0] MODE_FREE = 2'd2;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_NO_FRAME = 2'd1;
    localparam logic [1:0] STATUS_NOTHING = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [FRAME_W-1:0] frame_number;
        logic kernel_mode;
        logic writable;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic [1:0] status;
        logic entry_write;
        logic entry_present;
        logic entry_writable;
        logic entry_user;
    } rsp_t;

    typedef struct packed {
        logic valid;
        rsp_t data;
    } seq_res_t;

    typedef struct packed {
        logic find_first;
        logic set;
    } bit_ctl_t;

endpackage

>>> rtl/fba_bit_unit.sv
// ----------------------------------------------------------------------------
// Frame bitmap bit unit
// Tests one bitmap word for a clear bit, picks the lowest clear bit or a
// given bit, and returns the word with that bit set or cleared.
// ----------------------------------------------------------------------------
module fba_bit_unit
(
    input  logic [31:0] word,
    input  logic [fba_pkg::BIT_W-1:0] bit_in,
    input  fba_pkg::bit_ctl_t ctl,
    output logic full,
    output logic [fba_pkg::BIT_W-1:0] bit_sel,
    output logic [31:0] word_out
);

    logic [fba_pkg::BIT_W-1:0] first_zero;
    logic [31:0] mask;

    always_comb
    begin
        first_zero = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!word[i])
            begin
                first_zero = fba_pkg::BIT_W'(i);
            end
        end
    end

    assign full = (word == fba_pkg::FULL_WORD);
    assign bit_sel = ctl.find_first ? first_zero : bit_in;
    assign mask = 32'd1 << bit_sel;
    assign word_out = ctl.set ? (word | mask) : (word & ~mask);

endmodule

>>> rtl/fba_seq.sv
// ----------------------------------------------------------------------------
// Frame bitmap sequencer
// Holds the bitmap memory, clears it after reset, and steps the bit unit
// over one word per cycle for allocation or over one word for reserve/free.
// ----------------------------------------------------------------------------
module fba_seq
#(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  fba_pkg::req_t req_word,
    input  logic [fba_pkg::EFF_W-1:0] eff_count,
    output fba_pkg::seq_res_t res,
    input  logic res_ack
);

    localparam int WORDS = (MAX_FRAMES + 31) / 32;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW = $clog2(WORDS + 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MOD   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    fba_pkg::req_t req_reg, req_next;
    fba_pkg::rsp_t rsp_reg, rsp_next;

    logic [31:0] mem [WORDS];
    logic [31:0] rdata_reg;
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [31:0] mem_wd;

    logic [CW-1:0] scan_lim;
    logic [CW-1:0] cnt_inc;
    logic [14:0] cur_word_idx;
    logic in_range;

    fba_pkg::bit_ctl_t bu_ctl;
    logic bu_full;
    logic [fba_pkg::BIT_W-1:0] bu_bit;
    logic [31:0] bu_word;

    fba_bit_unit u_bit_unit
    (
        .word     (rdata_reg),
        .bit_in   (req_reg.frame_number[fba_pkg::BIT_W-1:0]),
        .ctl      (bu_ctl),
        .full     (bu_full),
        .bit_sel  (bu_bit),
        .word_out (bu_word)
    );

    assign scan_lim = CW'(eff_count >> 5);
    assign cnt_inc = cnt_reg + CW'(1);
    assign cur_word_idx = req_reg.frame_number[fba_pkg::FRAME_W-1:5];
    assign in_range = ({1'b0, req_word.frame_number} < eff_count);
    assign req_stall = (state_reg != S_IDLE);
    assign res.valid = (state_reg == S_DONE);
    assign res.data = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        req_next = req_reg;
        rsp_next = rsp_reg;
        mem_we = 1'b0;
        mem_wa = cur_word_idx[AW-1:0];
        mem_wd = bu_word;
        bu_ctl.find_first = (req_reg.mode == fba_pkg::MODE_ALLOC);
        bu_ctl.set = (req_reg.mode != fba_pkg::MODE_FREE);
        if (state_reg == S_SCAN)
        begin
            mem_ra = cnt_inc[AW-1:0];
        end
        else if (req_reg.mode == fba_pkg::MODE_ALLOC)
        begin
            mem_ra = '0;
        end
        else
        begin
            mem_ra = cur_word_idx[AW-1:0];
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg[AW-1:0];
                mem_wd = '0;
                cnt_next = cnt_inc;
                if (cnt_reg == CW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_word;
                    rsp_next = '0;
                    rsp_next.status = fba_pkg::STATUS_NOTHING;
                    state_next = S_DONE;
                    unique case (req_word.mode)
                        fba_pkg::MODE_ALLOC:
                        begin
                            if (req_word.frame_number == '0)
                            begin
                                if (scan_lim == '0)
                                begin
                                    rsp_next.status = fba_pkg::STATUS_NO_FRAME;
                                end
                                else
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        fba_pkg::MODE_RESERVE:
                        begin
                            rsp_next.result_frame = req_word.frame_number;
                            rsp_next.status = fba_pkg::STATUS_DONE;
                            rsp_next.entry_write = 1'b1;
                            rsp_next.entry_present = 1'b1;
                            rsp_next.entry_writable = req_word.writable;
                            rsp_next.entry_user = ~req_word.kernel_mode;
                            if (in_range)
                            begin
                                state_next = S_READ;
                            end
                        end
                        fba_pkg::MODE_FREE:
                        begin
                            if (req_word.frame_number != '0)
                            begin
                                rsp_next.status = fba_pkg::STATUS_DONE;
                                rsp_next.entry_write = 1'b1;
                                if (in_range)
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            rsp_next.status = fba_pkg::STATUS_NOTHING;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cnt_next = '0;
                if (req_reg.mode == fba_pkg::MODE_ALLOC)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_MOD;
                end
            end
            S_SCAN:
            begin
                if (!bu_full)
                begin
                    mem_we = 1'b1;
                    mem_wa = cnt_reg[AW-1:0];
                    rsp_next.result_frame = fba_pkg::FRAME_W'({cnt_reg, bu_bit});
                    rsp_next.status = fba_pkg::STATUS_DONE;
                    rsp_next.entry_write = 1'b1;
                    rsp_next.entry_present = 1'b1;
                    rsp_next.entry_writable = req_reg.writable;
                    rsp_next.entry_user = ~req_reg.kernel_mode;
                    state_next = S_DONE;
                end
                else if (cnt_inc == scan_lim)
                begin
                    rsp_next.status = fba_pkg::STATUS_NO_FRAME;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            S_MOD:
            begin
                mem_we = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

endmodule

>>> rtl/frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// Frame bitmap allocator core
// First-fit physical frame allocator over a one-bit-per-frame bitmap memory,
// with reserve and free requests and a page entry word for each request.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Word type
//   request   req_valid, req_stall, req_word   fba_pkg::req_t
//   response  rsp_valid, rsp_stall, rsp_word   fba_pkg::rsp_t
//   config    cfg_write, cfg_data              frame_count, 16 bits
//
// After reset the bitmap memory is cleared one word per cycle, (MAX_FRAMES+31)/32
// words (1024 by default), while requests are stalled.
// An allocation scans the bitmap words in order from word 0, up to frame_count/32
// words with frame_count clamped to MAX_FRAMES; reserve and free in range read,
// modify and write back one word. The single read port of the bitmap memory sets
// the scan rate.
// A request is taken while the previous response waits in the output register.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core
#(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [fba_pkg::COUNT_W-1:0] cfg_data,
    input  logic req_valid,
    output logic req_stall,
    input  fba_pkg::req_t req_word,
    output logic rsp_valid,
    input  logic rsp_stall,
    output fba_pkg::rsp_t rsp_word
);

    localparam logic [fba_pkg::EFF_W-1:0] MAX_CNT = fba_pkg::EFF_W'(MAX_FRAMES);

    logic [fba_pkg::COUNT_W-1:0] frame_count_reg, frame_count_next;
    logic rsp_valid_reg, rsp_valid_next;
    fba_pkg::rsp_t rsp_word_reg, rsp_word_next;

    logic [fba_pkg::EFF_W-1:0] count_ext;
    logic [fba_pkg::EFF_W-1:0] eff_count;
    fba_pkg::seq_res_t res;
    logic res_ack;

    fba_seq
    #(
        .MAX_FRAMES (MAX_FRAMES)
    )
    u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .eff_count (eff_count),
        .res       (res),
        .res_ack   (res_ack)
    );

    assign count_ext = fba_pkg::EFF_W'(frame_count_reg);
    assign eff_count = (count_ext > MAX_CNT) ? MAX_CNT : count_ext;
    assign res_ack = res.valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        frame_count_next = cfg_write ? cfg_data : frame_count_reg;
        rsp_word_next = rsp_word_reg;
        if (res_ack)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next = res.data;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= fba_pkg::FRAME_COUNT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word = rsp_word_reg;

endmodule
